// ===== design/pwmd_pkg.sv =====
// ----------------------------------------------------------------------------
// pwmd_pkg
// Shared types and codes for the peer-wire message deframer.
// ----------------------------------------------------------------------------
package pwmd_pkg;

    // Event codes on the result side
    localparam logic [3:0] EV_KEEPALIVE     = 4'd0;
    localparam logic [3:0] EV_CHOKE         = 4'd1;
    localparam logic [3:0] EV_UNCHOKE       = 4'd2;
    localparam logic [3:0] EV_INTERESTED    = 4'd3;
    localparam logic [3:0] EV_NOTINTERESTED = 4'd4;
    localparam logic [3:0] EV_HAVE          = 4'd5;
    localparam logic [3:0] EV_BITFIELD      = 4'd6;
    localparam logic [3:0] EV_REQUEST       = 4'd7;
    localparam logic [3:0] EV_PIECE         = 4'd8;
    localparam logic [3:0] EV_CANCEL        = 4'd9;
    localparam logic [3:0] EV_ERROR         = 4'd10;

    // Error kinds
    localparam logic [1:0] ERR_UNKNOWN_ID  = 2'd0;
    localparam logic [1:0] ERR_CTRL_LENGTH = 2'd1;
    localparam logic [1:0] ERR_PIECE_SHORT = 2'd2;

    // Message ids on the wire
    localparam logic [7:0] ID_LAST_CTRL = 8'd3;
    localparam logic [7:0] ID_HAVE      = 8'd4;
    localparam logic [7:0] ID_BITFIELD  = 8'd5;
    localparam logic [7:0] ID_REQUEST   = 8'd6;
    localparam logic [7:0] ID_PIECE     = 8'd7;
    localparam logic [7:0] ID_MAX       = 8'd8;

    // Length constants
    localparam logic [31:0] LEN_ID_ONLY   = 32'd1;
    localparam logic [31:0] LEN_PIECE_MIN = 32'd9;
    // Final-byte tests: count + 1 == length - header, i.e. count + header + 1 == length
    localparam logic [31:0] BF_LAST_ADD   = 32'd2;
    localparam logic [31:0] PC_LAST_ADD   = 32'd10;

    typedef enum logic [9:0] {
        PH_LEN      = 10'b00_0000_0001,
        PH_ID       = 10'b00_0000_0010,
        PH_HAVE     = 10'b00_0000_0100,
        PH_BLK_IDX  = 10'b00_0000_1000,
        PH_BLK_OFF  = 10'b00_0001_0000,
        PH_BLK_LEN  = 10'b00_0010_0000,
        PH_BITFIELD = 10'b00_0100_0000,
        PH_PC_IDX   = 10'b00_1000_0000,
        PH_PC_OFF   = 10'b01_0000_0000,
        PH_PC_DATA  = 10'b10_0000_0000
    } phase_t;

endpackage

// ===== design/peer_wire_message_deframer_core.sv =====
// ----------------------------------------------------------------------------
// peer_wire_message_deframer_core
// Splits a peer-wire byte stream into messages and emits one event per word.
// ----------------------------------------------------------------------------
// Takes one stream byte per input word and returns at most one event word per
// input word, in the cycle after the byte is taken. Throughput is one byte per
// clock: the parser state and the result register are both updated in the
// same cycle, and a new byte is taken whenever the result register is empty
// or being drained. Unknown ids, control messages of the wrong length and short
// pieces give an error event, and parsing restarts at the length.
module peer_wire_message_deframer_core
    import pwmd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] piece_index, [63:32] block_offset, [95:64] block_length,
    // [103:96] payload_byte, [135:104] byte_index
    output logic [135:0] m_axis_tdata,
    output logic         m_axis_tlast,   // last_of_payload
    output logic [7:0]   m_axis_tuser    // [3:0] event_res, [5:4] error_kind
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] msg_len_reg, msg_len_next;
    logic        is_request_reg, is_request_next;
    logic [31:0] held_idx_reg, held_idx_next;
    logic [31:0] held_off_reg, held_off_next;
    logic [31:0] pay_cnt_reg, pay_cnt_next;

    logic        out_valid_reg;
    logic [3:0]  ev_reg, ev_next;
    logic [31:0] o_idx_reg, o_idx_next;
    logic [31:0] o_off_reg, o_off_next;
    logic [31:0] o_blen_reg, o_blen_next;
    logic [7:0]  o_pb_reg, o_pb_next;
    logic [31:0] o_bi_reg, o_bi_next;
    logic        o_last_reg, o_last_next;
    logic [1:0]  o_ek_reg, o_ek_next;
    logic        emit;

    logic        in_accept;
    logic [31:0] shifted;
    logic        field_done;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign shifted       = {shift_reg[23:0], s_axis_tdata};
    assign field_done    = (cnt_reg == 2'd3);

    always_comb
    begin
        phase_next      = phase_reg;
        cnt_next        = cnt_reg + 2'd1;
        shift_next      = shifted;
        msg_len_next    = msg_len_reg;
        is_request_next = is_request_reg;
        held_idx_next   = held_idx_reg;
        held_off_next   = held_off_reg;
        pay_cnt_next    = pay_cnt_reg;
        emit            = 1'b0;
        ev_next         = EV_KEEPALIVE;
        o_idx_next      = '0;
        o_off_next      = '0;
        o_blen_next     = '0;
        o_pb_next       = '0;
        o_bi_next       = '0;
        o_last_next     = 1'b0;
        o_ek_next       = ERR_UNKNOWN_ID;

        unique case (phase_reg)
            PH_ID:
            begin
                cnt_next     = 2'd0;
                shift_next   = '0;
                pay_cnt_next = '0;
                phase_next   = PH_LEN;
                if (s_axis_tdata > ID_MAX)
                begin
                    emit    = 1'b1;
                    ev_next = EV_ERROR;
                end
                else if (s_axis_tdata <= ID_LAST_CTRL)
                begin
                    emit = 1'b1;
                    if (msg_len_reg != LEN_ID_ONLY)
                    begin
                        ev_next   = EV_ERROR;
                        o_ek_next = ERR_CTRL_LENGTH;
                    end
                    else
                    begin
                        ev_next = s_axis_tdata[3:0] + 4'd1;
                    end
                end
                else if (s_axis_tdata == ID_HAVE)
                begin
                    phase_next = PH_HAVE;
                end
                else if (s_axis_tdata == ID_BITFIELD)
                begin
                    // empty bitfield ends quietly
                    if (msg_len_reg != LEN_ID_ONLY)
                        phase_next = PH_BITFIELD;
                end
                else if (s_axis_tdata == ID_PIECE)
                begin
                    if (msg_len_reg < LEN_PIECE_MIN)
                    begin
                        emit      = 1'b1;
                        ev_next   = EV_ERROR;
                        o_ek_next = ERR_PIECE_SHORT;
                    end
                    else
                    begin
                        phase_next = PH_PC_IDX;
                    end
                end
                else
                begin
                    is_request_next = (s_axis_tdata == ID_REQUEST);
                    phase_next      = PH_BLK_IDX;
                end
            end

            PH_HAVE:
            begin
                if (field_done)
                begin
                    emit       = 1'b1;
                    ev_next    = EV_HAVE;
                    o_idx_next = shifted;
                    phase_next = PH_LEN;
                end
            end

            PH_BLK_IDX, PH_PC_IDX:
            begin
                if (field_done)
                begin
                    held_idx_next = shifted;
                    shift_next    = '0;
                    phase_next    = (phase_reg == PH_BLK_IDX) ? PH_BLK_OFF : PH_PC_OFF;
                end
            end

            PH_BLK_OFF:
            begin
                if (field_done)
                begin
                    held_off_next = shifted;
                    shift_next    = '0;
                    phase_next    = PH_BLK_LEN;
                end
            end

            PH_BLK_LEN:
            begin
                if (field_done)
                begin
                    emit        = 1'b1;
                    ev_next     = is_request_reg ? EV_REQUEST : EV_CANCEL;
                    o_idx_next  = held_idx_reg;
                    o_off_next  = held_off_reg;
                    o_blen_next = shifted;
                    phase_next  = PH_LEN;
                end
            end

            PH_PC_OFF:
            begin
                if (field_done)
                begin
                    held_off_next = shifted;
                    shift_next    = '0;
                    pay_cnt_next  = '0;
                    // no data bytes in a nine-byte piece
                    phase_next    = (msg_len_reg == LEN_PIECE_MIN) ? PH_LEN : PH_PC_DATA;
                end
            end

            PH_BITFIELD:
            begin
                cnt_next    = cnt_reg;
                shift_next  = shift_reg;
                emit        = 1'b1;
                ev_next     = EV_BITFIELD;
                o_pb_next   = s_axis_tdata;
                o_bi_next   = pay_cnt_reg;
                o_last_next = (pay_cnt_reg + BF_LAST_ADD == msg_len_reg);
                if (o_last_next)
                    phase_next = PH_LEN;
                else
                    pay_cnt_next = pay_cnt_reg + 32'd1;
            end

            PH_PC_DATA:
            begin
                cnt_next    = cnt_reg;
                shift_next  = shift_reg;
                emit        = 1'b1;
                ev_next     = EV_PIECE;
                o_idx_next  = held_idx_reg;
                o_off_next  = held_off_reg + pay_cnt_reg;
                o_pb_next   = s_axis_tdata;
                o_last_next = (pay_cnt_reg + PC_LAST_ADD == msg_len_reg);
                if (o_last_next)
                    phase_next = PH_LEN;
                else
                    pay_cnt_next = pay_cnt_reg + 32'd1;
            end

            default:
            begin
                // length field, big-endian
                if (field_done)
                begin
                    shift_next = '0;
                    if (shifted == '0)
                    begin
                        emit    = 1'b1;
                        ev_next = EV_KEEPALIVE;
                    end
                    else
                    begin
                        msg_len_next = shifted;
                        phase_next   = PH_ID;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEN;
            cnt_reg        <= '0;
            shift_reg      <= '0;
            msg_len_reg    <= '0;
            is_request_reg <= 1'b0;
            held_idx_reg   <= '0;
            held_off_reg   <= '0;
            pay_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                phase_reg      <= phase_next;
                cnt_reg        <= cnt_next;
                shift_reg      <= shift_next;
                msg_len_reg    <= msg_len_next;
                is_request_reg <= is_request_next;
                held_idx_reg   <= held_idx_next;
                held_off_reg   <= held_off_next;
                pay_cnt_reg    <= pay_cnt_next;
                out_valid_reg  <= emit;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
        begin
            ev_reg     <= ev_next;
            o_idx_reg  <= o_idx_next;
            o_off_reg  <= o_off_next;
            o_blen_reg <= o_blen_next;
            o_pb_reg   <= o_pb_next;
            o_bi_reg   <= o_bi_next;
            o_last_reg <= o_last_next;
            o_ek_reg   <= o_ek_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {o_bi_reg, o_pb_reg, o_blen_reg, o_off_reg, o_idx_reg};
    assign m_axis_tlast  = o_last_reg;
    assign m_axis_tuser  = {2'b00, o_ek_reg, ev_reg};

    // last only marks payload byte words
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (ev_reg == EV_BITFIELD || ev_reg == EV_PIECE))
        else $error("tlast on a non-payload word");

    // a non-zero error kind only travels with an error word
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && o_ek_reg != ERR_UNKNOWN_ID) |-> (ev_reg == EV_ERROR))
        else $error("error kind on a non-error word");

    // an out-of-range id gives an error word and a return to the length field
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && phase_reg == PH_ID && s_axis_tdata > ID_MAX)
        |=> (m_axis_tvalid && ev_reg == EV_ERROR && phase_reg == PH_LEN))
        else $error("unknown id not flagged");

    // the field counter is idle while payload bytes stream through
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BITFIELD || phase_reg == PH_PC_DATA) |-> (cnt_reg == 2'd0))
        else $error("field counter busy in payload phase");

endmodule

// ===== tb/peer_wire_message_deframer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_wire_message_deframer_core_tb
// Self-checking bench for the peer-wire message deframer.
// ----------------------------------------------------------------------------
// Streams raw peer-wire bytes into the core and checks every event word
// against an in-bench parser model. A directed run of hand-built messages
// comes first, then random well-formed messages with random content, mixed
// with malformed ones, and some raw noise at the end. Both stream sides idle
// at random in several phases. In one stretch the event side holds off for
// a long time so that the core backs up onto its byte input.
// ----------------------------------------------------------------------------
module peer_wire_message_deframer_core_tb;
    import pwmd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned BYTE_TARGET  = 600;
    localparam int unsigned NOISE_BYTES  = 24;

    typedef struct packed {
        logic [3:0]  ev;
        logic [1:0]  ek;
        logic        last;
        logic [31:0] idx;
        logic [31:0] off;
        logic [31:0] blen;
        logic [7:0]  pbyte;
        logic [31:0] bidx;
    } event_t;

    logic         clk;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;   // [7:0] data_byte
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [31:0] piece_index, [63:32] block_offset, [95:64] block_length,
    // [103:96] payload_byte, [135:104] byte_index
    logic [135:0] m_axis_tdata;
    logic         m_axis_tlast;        // last_of_payload
    logic [7:0]   m_axis_tuser;        // [3:0] event_res, [5:4] error_kind

    peer_wire_message_deframer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    logic [7:0]  wire_bytes[$];
    event_t      expected_events[$];
    int unsigned bytes_taken = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_start = 1'b0;
    int unsigned hold_count = 0;
    logic        hold_active;

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    phase_t      dp_phase = PH_LEN;
    logic [1:0]  dp_count = '0;
    logic [31:0] dp_shift = '0;
    logic [31:0] dp_len = '0;
    logic [7:0]  dp_id = '0;
    logic [31:0] dp_index = '0;
    logic [31:0] dp_offset = '0;
    logic [31:0] dp_paycount = '0;

    function automatic void clear_message();
        dp_phase    = PH_LEN;
        dp_count    = '0;
        dp_shift    = '0;
        dp_len      = '0;
        dp_id       = '0;
        dp_index    = '0;
        dp_offset   = '0;
        dp_paycount = '0;
    endfunction

    // big-endian field shifter, true once four bytes are in
    function automatic bit shift_field(input logic [7:0] b);
        dp_shift = {dp_shift[23:0], b};
        if (dp_count == 2'd3)
        begin
            dp_count = '0;
            return 1'b1;
        end
        dp_count = dp_count + 2'd1;
        return 1'b0;
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output event_t r);
        logic [31:0] v;
        bit          got;
        r   = '0;
        got = 1'b0;
        case (dp_phase)
            PH_ID:
            begin
                if (b > ID_MAX)
                begin
                    clear_message();
                    r.ev = EV_ERROR;
                    r.ek = ERR_UNKNOWN_ID;
                    got  = 1'b1;
                end
                else if (b <= ID_LAST_CTRL)
                begin
                    if (dp_len != LEN_ID_ONLY)
                    begin
                        r.ev = EV_ERROR;
                        r.ek = ERR_CTRL_LENGTH;
                    end
                    else
                        r.ev = EV_CHOKE + b[3:0];
                    clear_message();
                    got = 1'b1;
                end
                else
                begin
                    dp_id       = b;
                    dp_count    = '0;
                    dp_shift    = '0;
                    dp_paycount = '0;
                    case (b)
                        ID_HAVE:
                            dp_phase = PH_HAVE;
                        ID_BITFIELD:
                            if (dp_len == LEN_ID_ONLY)
                                clear_message();
                            else
                                dp_phase = PH_BITFIELD;
                        ID_PIECE:
                            if (dp_len < LEN_PIECE_MIN)
                            begin
                                clear_message();
                                r.ev = EV_ERROR;
                                r.ek = ERR_PIECE_SHORT;
                                got  = 1'b1;
                            end
                            else
                                dp_phase = PH_PC_IDX;
                        default:
                            dp_phase = PH_BLK_IDX;
                    endcase
                end
            end
            PH_HAVE:
                if (shift_field(b))
                begin
                    r.ev  = EV_HAVE;
                    r.idx = dp_shift;
                    clear_message();
                    got   = 1'b1;
                end
            PH_BLK_IDX, PH_PC_IDX:
                if (shift_field(b))
                begin
                    dp_index = dp_shift;
                    dp_shift = '0;
                    dp_phase = (dp_phase == PH_BLK_IDX) ? PH_BLK_OFF : PH_PC_OFF;
                end
            PH_BLK_OFF:
                if (shift_field(b))
                begin
                    dp_offset = dp_shift;
                    dp_shift  = '0;
                    dp_phase  = PH_BLK_LEN;
                end
            PH_BLK_LEN:
                if (shift_field(b))
                begin
                    r.ev   = (dp_id == ID_REQUEST) ? EV_REQUEST : EV_CANCEL;
                    r.idx  = dp_index;
                    r.off  = dp_offset;
                    r.blen = dp_shift;
                    clear_message();
                    got    = 1'b1;
                end
            PH_PC_OFF:
                if (shift_field(b))
                begin
                    dp_offset = dp_shift;
                    dp_shift  = '0;
                    if (dp_len == LEN_PIECE_MIN)
                        clear_message();
                    else
                        dp_phase = PH_PC_DATA;
                end
            PH_BITFIELD:
            begin
                v       = dp_paycount;
                r.ev    = EV_BITFIELD;
                r.pbyte = b;
                r.bidx  = v;
                r.last  = ((v + 32'd1) == (dp_len - LEN_ID_ONLY));
                if (r.last)
                    clear_message();
                else
                    dp_paycount = v + 32'd1;
                got = 1'b1;
            end
            PH_PC_DATA:
            begin
                v       = dp_paycount;
                r.ev    = EV_PIECE;
                r.idx   = dp_index;
                r.off   = dp_offset + v;
                r.pbyte = b;
                r.last  = ((v + 32'd1) == (dp_len - LEN_PIECE_MIN));
                if (r.last)
                    clear_message();
                else
                    dp_paycount = v + 32'd1;
                got = 1'b1;
            end
            default:
            begin
                if (dp_phase != PH_LEN)
                    clear_message();
                if (shift_field(b))
                begin
                    v        = dp_shift;
                    dp_shift = '0;
                    if (v == 32'd0)
                    begin
                        clear_message();
                        r.ev = EV_KEEPALIVE;
                        got  = 1'b1;
                    end
                    else
                    begin
                        dp_len   = v;
                        dp_phase = PH_ID;
                    end
                end
            end
        endcase
        return got;
    endfunction

    // ------------------------------------------------------------------
    // Message builders
    // ------------------------------------------------------------------
    task automatic put_word(input logic [31:0] w);
        wire_bytes.push_back(w[31:24]);
        wire_bytes.push_back(w[23:16]);
        wire_bytes.push_back(w[15:8]);
        wire_bytes.push_back(w[7:0]);
    endtask

    task automatic put_random_bytes(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            wire_bytes.push_back(8'($urandom));
    endtask

    task automatic put_head(input logic [31:0] len, input logic [7:0] id);
        put_word(len);
        wire_bytes.push_back(id);
    endtask

    task automatic put_block_msg(input logic [7:0] id, input logic [31:0] len,
                                 input logic [31:0] idx, input logic [31:0] off,
                                 input logic [31:0] blen);
        put_head(len, id);
        put_word(idx);
        put_word(off);
        put_word(blen);
    endtask

    task automatic put_bitfield(input int unsigned n);
        put_head(32'(n) + LEN_ID_ONLY, ID_BITFIELD);
        put_random_bytes(n);
    endtask

    task automatic put_piece(input logic [31:0] idx, input logic [31:0] off,
                             input int unsigned n);
        put_head(32'(n) + LEN_PIECE_MIN, ID_PIECE);
        put_word(idx);
        put_word(off);
        put_random_bytes(n);
    endtask

    task automatic build_directed();
        put_word(32'd0);                                  // keep-alive
        for (int i = 0; i <= int'(ID_LAST_CTRL); i++)
            put_head(LEN_ID_ONLY, 8'(i));
        put_head(32'hFFFF_FFFF, 8'd2);                    // control id, bad length
        put_head(32'd2, 8'd0);
        put_head(LEN_ID_ONLY, ID_MAX + 8'd1);             // unknown ids
        put_head(32'h8000_0000, 8'hFF);
        put_head(LEN_PIECE_MIN - 32'd1, ID_PIECE);        // short pieces
        put_head(LEN_ID_ONLY, ID_PIECE);
        put_bitfield(0);                                  // empty payloads
        put_piece(32'h1234_5678, 32'h0000_0010, 0);
        put_head(32'd5, ID_HAVE);
        put_word(32'hFFFF_FFFF);
        put_head(LEN_ID_ONLY, ID_HAVE);                   // declared length ignored
        put_word(32'h0000_0000);
        put_block_msg(ID_REQUEST, 32'd13, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_block_msg(ID_MAX, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
        put_block_msg(ID_MAX, 32'd13, 32'hA5A5_5A5A, 32'h0000_4000, 32'h0000_4000);
        put_bitfield(1);
        put_bitfield(3);
        put_piece(32'hFFFF_FFFF, 32'hFFFF_FFFE, 4);       // offset wraps
        put_piece(32'd0, 32'd0, 2);
        put_word(32'd0);
    endtask

    task automatic build_random();
        int unsigned pick;
        int unsigned n;
        logic [31:0] len;
        logic [31:0] off;
        while (wire_bytes.size() < BYTE_TARGET - NOISE_BYTES)
        begin
            pick = $urandom_range(0, 99);
            len  = $urandom;
            if (len < 32'd2)
                len = 32'd2;
            if (pick < 8)
                put_word(32'd0);
            else if (pick < 20)
                put_head(LEN_ID_ONLY, 8'($urandom_range(0, int'(ID_LAST_CTRL))));
            else if (pick < 30)
            begin
                put_head(($urandom_range(0, 3) == 0) ? len : 32'd5, ID_HAVE);
                put_word($urandom);
            end
            else if (pick < 42)
                put_block_msg(($urandom_range(0, 1) == 0) ? ID_REQUEST : ID_MAX,
                              ($urandom_range(0, 3) == 0) ? len : 32'd13,
                              $urandom, $urandom, $urandom);
            else if (pick < 58)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                 : $urandom_range(1, 16);
                put_bitfield(n);
            end
            else if (pick < 74)
            begin
                case ($urandom_range(0, 2))
                    0:       off = $urandom;
                    1:       off = 32'hFFFF_FFFF - 32'($urandom_range(0, 8));
                    default: off = 32'd0;
                endcase
                put_piece($urandom, off, $urandom_range(1, 16));
            end
            else if (pick < 80)
            begin
                if ($urandom_range(0, 1) == 0)
                    put_bitfield(0);
                else
                    put_piece($urandom, $urandom, 0);
            end
            else if (pick < 87)
                put_head(len, 8'($urandom_range(0, int'(ID_LAST_CTRL))));
            else if (pick < 94)
                put_head(len - 32'd1, 8'($urandom_range(int'(ID_MAX) + 1, 255)));
            else
                put_head(32'($urandom_range(1, 8)), ID_PIECE);
        end
        // raw noise; the parser may be left anywhere after this
        put_random_bytes(NOISE_BYTES);
    endtask

    // ------------------------------------------------------------------
    // Byte driver, with prediction on every accepted word
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        event_t r;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                bytes_taken <= bytes_taken + 1;
                if (deframe_byte(s_axis_tdata, r))
                    expected_events.push_back(r);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (wire_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= wire_bytes.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long hold-off on the event side
    assign hold_active = hold_start && (hold_count < HOLD_CYCLES);

    always @(posedge clk)
    begin
        if (hold_active)
            hold_count <= hold_count + 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Event monitor
    // ------------------------------------------------------------------
    function automatic string event_text(input event_t e);
        return $sformatf("ev=%0d ek=%0d last=%b idx=%h off=%h len=%h byte=%h bidx=%h",
                         e.ev, e.ek, e.last, e.idx, e.off, e.blen, e.pbyte, e.bidx);
    endfunction

    always @(posedge clk)
    begin
        event_t seen;
        event_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.ev    = m_axis_tuser[3:0];
            seen.ek    = m_axis_tuser[5:4];
            seen.last  = m_axis_tlast;
            seen.idx   = m_axis_tdata[31:0];
            seen.off   = m_axis_tdata[63:32];
            seen.blen  = m_axis_tdata[95:64];
            seen.pbyte = m_axis_tdata[103:96];
            seen.bidx  = m_axis_tdata[135:104];
            if (expected_events.size() == 0)
            begin
                fail_count <= fail_count + 1;
                if (fail_count < 10)
                    $display("%0t: unexpected event word: %s", $realtime, event_text(seen));
            end
            else
            begin
                want = expected_events.pop_front();
                if (seen.ev !== want.ev || seen.ek !== want.ek || seen.last !== want.last
                    || seen.idx !== want.idx || seen.off !== want.off
                    || seen.blen !== want.blen || seen.pbyte !== want.pbyte
                    || seen.bidx !== want.bidx || m_axis_tuser[7:6] !== 2'b00)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                    begin
                        $display("%0t: event mismatch", $realtime);
                        $display("    expected %s", event_text(want));
                        $display("    actual   %s tuser=%h", event_text(seen), m_axis_tuser);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned total;
        build_directed();
        build_random();
        total = wire_bytes.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // sender keeps offering while the event side is held off
        while (bytes_taken < total / 8)
            @(posedge clk);
        hold_start <= 1'b1;
        while (bytes_taken < total / 4)
            @(posedge clk);
        sender_idle_pct <= 56;
        while (bytes_taken < total / 2)
            @(posedge clk);
        sender_idle_pct <= 0;
        recv_stall_pct  <= 56;
        while (bytes_taken < (3 * total) / 4)
            @(posedge clk);
        sender_idle_pct <= 35;
        recv_stall_pct  <= 35;

        while (wire_bytes.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_events.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
